>>> src/assert_macros.svh
// Assertion macros shared by the arm inverse kinematics RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/tlik_pkg.sv
// Types and constants of the arm inverse kinematics block
package tlik_pkg;
  localparam int TabFrac = 20;
  localparam int TabLen  = 24;
  localparam int NormBit = 39;
  localparam int AccW    = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZHIGH = 2'd1;
  localparam logic [1:0] ST_UNRCH = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_SQ     = 4'd2;
  localparam logic [3:0] OP_SQRT_S = 4'd3;
  localparam logic [3:0] OP_SQRT   = 4'd4;
  localparam logic [3:0] OP_GEOM   = 4'd5;
  localparam logic [3:0] OP_CHECK  = 4'd6;
  localparam logic [3:0] OP_ATAN_S = 4'd7;
  localparam logic [3:0] OP_NORM   = 4'd8;
  localparam logic [3:0] OP_PRE    = 4'd9;
  localparam logic [3:0] OP_ROT    = 4'd10;
  localparam logic [3:0] OP_ATAN_E = 4'd11;
  localparam logic [3:0] OP_FINISH = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;   // sqrt: 0 reach, 1 h; atan: 0 gamma 1 alpha 2 beta 3 base
    logic [4:0] step;
  } tlik_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic norm_done;
    logic unreach;
  } tlik_sts_t;

  function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] i);
    logic signed [AccW-1:0] v;
    case (i)
      5'd0: v = 47185920;  5'd1: v = 27855475;  5'd2: v = 14718068;
      5'd3: v = 7471121;   5'd4: v = 3750058;   5'd5: v = 1876857;
      5'd6: v = 938658;    5'd7: v = 469357;    5'd8: v = 234682;
      5'd9: v = 117342;    5'd10: v = 58671;    5'd11: v = 29335;
      5'd12: v = 14668;    5'd13: v = 7334;     5'd14: v = 3667;
      5'd15: v = 1833;     5'd16: v = 917;      5'd17: v = 458;
      5'd18: v = 229;      5'd19: v = 115;      5'd20: v = 57;
      5'd21: v = 29;       5'd22: v = 14;       5'd23: v = 7;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

>>> src/three_link_arm_inverse_kinematics.sv
// Each target passes through set-up, two square roots (reach, then h) and four CORDICs
// (gamma, alpha, beta, base), each CORDIC preceded by a normalising doubling loop.
// The next item is taken only once the result of the last sits in the output register.
// A z over limit skips the computation and goes straight to the output state; an out-of-reach
// target stops after the reach check. Output back-pressure stalls the block in its last state.
// Synchronous active-low reset restores register defaults and clears held angles and gripper.
`include "assert_macros.svh"
module three_link_arm_inverse_kinematics
  import tlik_pkg::*;
#(
  parameter int AngleFracBits = 6,
  parameter int CordicSteps   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // target_x, target_y, target_z, gripper_cmd, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // base_angle, shoulder_angle, elbow_angle, gripper_state,
                                  // status, zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [2:0] R_L0 = 3'd0, R_L1 = 3'd1, R_L2 = 3'd2, R_L3 = 3'd3, R_LIM = 3'd4;

  logic [14:0] l0_r, l1_r, l2_r, l3_r;
  logic signed [15:0] lim_r;
  logic signed [14:0] hb_r;
  logic signed [15:0] hs_r, he_r;
  logic hg_r, grip_r, zh_r, ov_r;
  logic [1:0] stat_r;
  logic [55:0] od_r;
  logic accept, wr, idle, done;
  tlik_cmd_t cmd;
  tlik_sts_t sts;
  logic signed [15:0] base_w, sh_w, el_w;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (cfg_paddr[4:2])
      R_L0:  cfg_prdata = {17'd0, l0_r};
      R_L1:  cfg_prdata = {17'd0, l1_r};
      R_L2:  cfg_prdata = {17'd0, l2_r};
      R_L3:  cfg_prdata = {17'd0, l3_r};
      R_LIM: cfg_prdata = {{16{lim_r[15]}}, lim_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign in_tready = idle;
  assign accept = in_tvalid && in_tready;

  tlik_ctrl #(.CordicSteps(CordicSteps)) u_ctrl (
    .clk, .rst_n, .start(accept),
    .z_high($signed(in_tdata[47:32]) > lim_r),
    .sts, .out_busy(ov_r && !out_tready), .cmd, .idle, .done
  );

  tlik_dp #(.AngleFracBits(AngleFracBits)) u_dp (
    .clk, .cmd, .tx(in_tdata[15:0]), .ty(in_tdata[31:16]), .tz(in_tdata[47:32]),
    .l0(l0_r), .l1(l1_r), .l2(l2_r), .l3(l3_r), .sts,
    .base_o(base_w), .sh_o(sh_w), .el_o(el_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_r <= 15'd1600; l1_r <= 15'd2400; l2_r <= 15'd2400; l3_r <= 15'd320;
      lim_r <= 16'sd4800;
      hb_r <= '0; hs_r <= '0; he_r <= '0; hg_r <= 1'b0;
      ov_r <= 1'b0; stat_r <= ST_OK; zh_r <= 1'b0; grip_r <= 1'b0;
    end else begin
      if (wr) begin
        case (cfg_paddr[4:2])
          R_L0:  l0_r <= cfg_pwdata[14:0];
          R_L1:  l1_r <= cfg_pwdata[14:0];
          R_L2:  l2_r <= cfg_pwdata[14:0];
          R_L3:  l3_r <= cfg_pwdata[14:0];
          R_LIM: lim_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        zh_r   <= $signed(in_tdata[47:32]) > lim_r;
        grip_r <= in_tdata[48];
        stat_r <= ST_OK;
      end
      if (cmd.op == OP_CHECK && sts.unreach) stat_r <= ST_UNRCH;
      if (cmd.op == OP_FINISH) begin
        hg_r <= grip_r;
        if (stat_r == ST_OK) begin
          hb_r <= base_w[14:0]; hs_r <= sh_w; he_r <= el_w;
        end
      end
      // hold the item until taken; a finished item refills the register
      ov_r <= done || (ov_r && !out_tready);
    end
  end

  // pack the result on completion, held angles when rejected
  always_ff @(posedge clk) begin
    if (done) begin
      od_r <= {6'd0, (zh_r ? ST_ZHIGH : stat_r), hg_r, he_r, hs_r, hb_r};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  `ASSERT_IMP(a_no_accept_busy, clk, rst_n, !idle, !in_tready)
  `ASSERT_NEXT(a_done_valid, clk, rst_n, done, out_tvalid)
  `ASSERT_IMP(a_done_free, clk, rst_n, done, !(ov_r && !out_tready))
endmodule

>>> src/tlik_ctrl.sv
// Sequencer of the arm inverse kinematics block
`include "assert_macros.svh"
module tlik_ctrl
  import tlik_pkg::*;
#(
  parameter int CordicSteps = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      z_high,
  input  tlik_sts_t sts,
  input  logic      out_busy,
  output tlik_cmd_t cmd,
  output logic      idle,
  output logic      done
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQS = 4'd2, S_SQRT = 4'd3,
    S_GEOM = 4'd4, S_CHK = 4'd5, S_AS = 4'd6, S_NORM = 4'd7, S_PRE = 4'd8,
    S_ROT = 4'd9, S_AE = 4'd10, S_FIN = 4'd11, S_OUT = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [4:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    step_nxt  = step_r;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    cmd.step  = step_r;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          state_nxt = z_high ? S_OUT : S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        sel_nxt = 2'd0;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op = OP_SQRT_S;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (sts.sqrt_done) begin
          if (sel_r == 2'd0) state_nxt = S_GEOM;
          else begin
            sel_nxt = 2'd0;
            state_nxt = S_AS;
          end
        end
      end
      S_GEOM: begin
        cmd.op = OP_GEOM;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.op = OP_CHECK;
        sel_nxt = 2'd1;
        state_nxt = sts.unreach ? S_FIN : S_SQS;
      end
      S_AS: begin
        cmd.op = OP_ATAN_S;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (sts.norm_done) state_nxt = S_PRE;
      end
      S_PRE: begin
        cmd.op = OP_PRE;
        step_nxt = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(CordicSteps - 1)) state_nxt = S_AE;
      end
      S_AE: begin
        cmd.op = OP_ATAN_E;
        sel_nxt = sel_r + 2'd1;
        state_nxt = (sel_r == 2'd3) ? S_FIN : S_AS;
      end
      S_FIN: begin
        cmd.op = OP_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      step_r  <= step_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  `ASSERT_IMP(a_step_range, clk, rst_n, state_r == S_ROT, step_r < 5'(CordicSteps))
  `ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, idle && start, !idle)
  `ASSERT_NEXT(a_done_idle, clk, rst_n, done, idle)
endmodule

>>> src/tlik_dp.sv
// Datapath of the arm inverse kinematics block: squares, root, CORDIC
module tlik_dp
  import tlik_pkg::*;
#(
  parameter int AngleFracBits = 6
) (
  input  logic               clk,
  input  tlik_cmd_t          cmd,
  input  logic signed [15:0] tx,
  input  logic signed [15:0] ty,
  input  logic signed [15:0] tz,
  input  logic [14:0]        l0,
  input  logic [14:0]        l1,
  input  logic [14:0]        l2,
  input  logic [14:0]        l3,
  output tlik_sts_t          sts,
  output logic signed [15:0] base_o,
  output logic signed [15:0] sh_o,
  output logic signed [15:0] el_o
);
  localparam int W = 66;
  localparam int Sh = TabFrac - AngleFracBits;

  logic signed [15:0] x_r, y_r, z_r;
  logic [32:0] sqx_r, sqy_r;
  logic [63:0] rad_r, rem_r, root_r, bit_r;
  logic [16:0] reach_r;
  logic signed [17:0] dx_r, dz_r;
  logic signed [35:0] dxx_r, dzz_r, l1s_r, l2s_r, l12_r;
  logic signed [37:0] g_r, lim_r;
  logic [32:0] h_r;
  logic signed [W-1:0] cx_r, cy_r;
  logic signed [AccW-1:0] acc_r;
  logic signed [19:0] gam_r, alp_r, bet_r, bas_r;

  logic signed [W-1:0] sx, sy, ax, ay, m;
  logic signed [AccW-1:0] rnd;
  logic signed [19:0] ang;
  logic [63:0] trial;
  logic signed [37:0] gw;
  logic [31:0] hu, hv;
  logic [63:0] hprod;

  assign trial = root_r + bit_r;
  assign ax = cx_r[W-1] ? -cx_r : cx_r;
  assign ay = cy_r[W-1] ? -cy_r : cy_r;
  assign m  = (ax > ay) ? ax : ay;
  assign sx = cx_r >>> cmd.step;
  assign sy = cy_r >>> cmd.step;
  assign rnd = (acc_r + (AccW'(1) <<< (Sh - 1))) >>> Sh;
  assign ang = rnd[19:0];
  assign gw = 38'(l1s_r) + 38'(l2s_r) - 38'(dx_r * dx_r) - 38'(dz_r * dz_r);
  // lim^2 - g^2 as (lim - g) * (lim + g); both factors fit 32 bits when reachable
  assign hu = 32'(lim_r - g_r);
  assign hv = 32'(lim_r + g_r);
  assign hprod = hu * hv;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r <= tx; y_r <= ty; z_r <= tz;
      end
      OP_SQ: begin
        sqx_r <= 33'(32'(x_r * x_r));
        sqy_r <= 33'(32'(y_r * y_r));
        l1s_r <= 36'(l1) * 36'(l1);
        l2s_r <= 36'(l2) * 36'(l2);
        l12_r <= 36'(l1) * 36'(l2);
      end
      OP_SQRT_S: begin
        rad_r  <= (cmd.sel == 2'd0) ? 64'(sqx_r) + 64'(sqy_r) : hprod;
        rem_r  <= (cmd.sel == 2'd0) ? 64'(sqx_r) + 64'(sqy_r) : hprod;
        root_r <= '0;
        bit_r  <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (bit_r > rad_r && root_r == '0) begin
          bit_r <= bit_r >> 2;
        end else if (bit_r != '0) begin
          if (rem_r >= trial) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          if (cmd.sel == 2'd0) reach_r <= 17'(root_r + 64'(rem_r > root_r));
          else h_r <= 33'(root_r + 64'(rem_r > root_r));
        end
      end
      OP_GEOM: begin
        dx_r <= 18'(signed'({1'b0, reach_r})) - 18'(signed'({1'b0, l3}));
        dz_r <= 18'(z_r) - 18'(signed'({1'b0, l0}));
        lim_r <= 38'(l12_r) <<< 1;
      end
      OP_CHECK: begin
        g_r <= gw;
      end
      OP_ATAN_S: begin
        acc_r <= '0;
        case (cmd.sel)
          2'd0: begin cx_r <= W'(g_r); cy_r <= W'(signed'({1'b0, h_r})); end
          2'd1: begin
            cx_r <= W'((38'(l1s_r) <<< 1) - g_r);
            cy_r <= W'(signed'({1'b0, h_r}));
          end
          2'd2: begin
            cx_r <= -W'(dz_r);
            cy_r <= dx_r[17] ? -W'(dx_r) : W'(dx_r);
          end
          default: begin cx_r <= W'(x_r); cy_r <= W'(y_r); end
        endcase
      end
      OP_NORM: begin
        if (m != '0 && m < (W'(1) <<< NormBit)) begin
          cx_r <= cx_r <<< 1; cy_r <= cy_r <<< 1;
        end
      end
      OP_PRE: begin
        if (cx_r[W-1]) begin
          if (!cy_r[W-1]) begin
            cx_r <= cy_r; cy_r <= -cx_r;
            acc_r <= AccW'(90) <<< TabFrac;
          end else begin
            cx_r <= -cy_r; cy_r <= cx_r;
            acc_r <= -(AccW'(90) <<< TabFrac);
          end
        end
      end
      OP_ROT: begin
        if (!cy_r[W-1]) begin
          cx_r <= cx_r + sy; cy_r <= cy_r - sx; acc_r <= acc_r + atan_entry(cmd.step);
        end else begin
          cx_r <= cx_r - sy; cy_r <= cy_r + sx; acc_r <= acc_r - atan_entry(cmd.step);
        end
      end
      OP_ATAN_E: begin
        case (cmd.sel)
          2'd0: gam_r <= (cx_r == '0 && cy_r == '0) ? '0 : ang;
          2'd1: alp_r <= (cx_r == '0 && cy_r == '0) ? '0 : ang;
          2'd2: bet_r <= (cx_r == '0 && cy_r == '0) ? '0 : ang;
          default: begin
            if (cx_r == '0 && cy_r == '0) bas_r <= '0;
            else if (ang > 20'(180 <<< AngleFracBits)) bas_r <= 20'(180 <<< AngleFracBits);
            else if (ang < -20'(180 <<< AngleFracBits)) bas_r <= -20'(180 <<< AngleFracBits);
            else bas_r <= ang;
          end
        endcase
      end
      default: ;
    endcase
  end

  logic signed [21:0] shw, elw;
  assign shw = 22'(270 <<< AngleFracBits) - 22'(bet_r) - 22'(alp_r);
  assign elw = shw - 22'(gam_r);

  assign sts.sqrt_done = (bit_r == '0) && !(bit_r > rad_r && root_r == '0);
  assign sts.norm_done = (m == '0) || !(m < (W'(1) <<< NormBit));
  assign sts.unreach   = (l1 == '0) || (l2 == '0) || (dx_r == '0 && dz_r == '0) ||
    (gw > lim_r) || (gw < -lim_r);
  assign base_o = bas_r[15:0];
  assign sh_o   = shw[15:0];
  assign el_o   = elw[15:0];
endmodule
